[hdl/gted_pkg.sv]
package gted_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned TallyW  = 2;

    localparam logic [ByteW-1:0]  IdleMax        = 8'hFF;
    localparam logic [TallyW-1:0] TallyFull      = 2'd3;
    localparam logic [ByteW-1:0]  EscCharReset   = 8'd43;   // '+'
    localparam logic [ByteW-1:0]  GuardReset     = 8'd50;   // 1 s at 50 ticks/s

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_ESCAPE_CHAR = 1'b0,
        CFG_GUARD_TICKS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic             is_tick;
        logic [ByteW-1:0] data_byte;
    } gted_in_t;

    typedef struct packed {
        logic              escape_detected;
        logic [TallyW-1:0] escape_seen;
    } gted_out_t;

    typedef struct packed {
        logic [ByteW-1:0] escape_char;
        logic [ByteW-1:0] guard_ticks;
    } gted_cfg_t;

endpackage

[hdl/guard_time_escape_detector_top.sv]
// Guard-time escape detector: one result word per input word.
// The result is registered in the output stage: in the result register, or in the skid entry behind a held result.
// Throughput: one word per cycle while the skid entry is free; a two-entry output stage
// (result + skid) keeps input accepting while one result waits for the consumer.
// Reset (rst_n, async low): idle count saturated, tally and wait cleared,
// escape char = '+', guard time = 50 ticks, output stage empty.
module guard_time_escape_detector_top (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  gted_pkg::gted_in_t   in_word,

    output logic                out_valid,
    input  logic                out_ready,
    output gted_pkg::gted_out_t  out_word,

    input  logic                cfg_we,
    input  gted_pkg::cfg_idx_t   cfg_index,
    input  logic [7:0]          cfg_data
);
    import gted_pkg::*;

    // configuration registers
    gted_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_char <= EscCharReset;
            cfg_reg.guard_ticks <= GuardReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ESCAPE_CHAR: cfg_reg.escape_char <= cfg_data;
                CFG_GUARD_TICKS: cfg_reg.guard_ticks <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // detector state and per-word update
    logic      in_accept;
    gted_out_t core_result;

    assign in_accept = in_valid && in_ready;

    gted_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_word (in_word),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // output stage: main result register plus one skid entry.
    // Input stalls only when both entries are full.
    gted_out_t out_reg;
    gted_out_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      out_pop;

    assign out_pop  = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;     // no accept possible here
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_accept)
            begin
                out_reg <= core_result;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= core_result;
            end
            else
            begin
                out_reg <= core_result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef SYNTHESIS
    // skid entry is only used behind a held result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output is empty");

    // an accepted word always lands somewhere
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word lost");

    // full stage with a stalled consumer stays full
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && out_valid_reg))
        else $error("output stage drained without a pop");
`endif

endmodule

[hdl/gted_core.sv]
module gted_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  gted_pkg::gted_in_t  in_word,
    input  gted_pkg::gted_cfg_t cfg,
    output gted_pkg::gted_out_t result
);
    import gted_pkg::*;

    logic [ByteW-1:0]  idle_reg,  idle_next;
    logic [TallyW-1:0] tally_reg, tally_next;
    logic              await_reg, await_next;
    logic              pulse;

    logic [ByteW-1:0]  idle_inc;
    logic [TallyW-1:0] tally_base;
    logic              quiet;

    always_comb
    begin
        idle_inc   = (idle_reg == IdleMax) ? IdleMax : idle_reg + 1'b1;
        tally_base = await_reg ? '0 : tally_reg;
        quiet      = (idle_reg >= cfg.guard_ticks);

        idle_next  = idle_reg;
        tally_next = tally_reg;
        await_next = await_reg;
        pulse      = 1'b0;

        if (in_word.is_tick)
        begin
            idle_next = idle_inc;
            if (await_reg && (idle_inc >= cfg.guard_ticks))
            begin
                pulse      = 1'b1;
                await_next = 1'b0;
                tally_next = '0;
            end
        end
        else
        begin
            // a byte while waiting drops the pending sequence first
            tally_next = tally_base;
            if (in_word.data_byte == cfg.escape_char)
            begin
                if (tally_base == '0)
                begin
                    tally_next = quiet ? TallyW'(1) : '0;
                end
                else if (tally_base != TallyFull)
                begin
                    tally_next = quiet ? TallyW'(1) : tally_base + 1'b1;
                end
            end
            else
            begin
                tally_next = '0;
            end
            idle_next  = '0;
            await_next = (tally_next == TallyFull);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= IdleMax;
            tally_reg <= '0;
            await_reg <= 1'b0;
        end
        else if (accept)
        begin
            idle_reg  <= idle_next;
            tally_reg <= tally_next;
            await_reg <= await_next;
        end
    end

    assign result.escape_detected = pulse;
    assign result.escape_seen     = tally_next;

`ifndef SYNTHESIS
    // waiting for trailing silence only ever follows a full tally
    a_await_full: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> (tally_reg == TallyFull))
        else $error("await set without full tally");

    // pulse clears the tally on the same word
    a_pulse_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pulse) |=> (tally_reg == '0 && !await_reg))
        else $error("pulse did not clear state");

    // any byte restarts the idle count
    a_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_word.is_tick) |=> (idle_reg == '0))
        else $error("idle count not restarted by byte");
`endif

endmodule
